### hdl/quadrant_detector_gain_calibration_unit_assert.svh
// assertion macros for the quadrant detector gain calibration unit
`ifndef QUADRANT_DETECTOR_GAIN_CALIBRATION_UNIT_ASSERT_SVH
`define QUADRANT_DETECTOR_GAIN_CALIBRATION_UNIT_ASSERT_SVH
// condition must hold in every cycle out of reset
`define QDG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// condition in one cycle implies the next one
`define QDG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/qdgc_pkg.sv
// shared constants for the quadrant detector gain calibration unit
`timescale 1ns / 1ps
package qdgc_pkg;
  localparam int CAL_W = 17;
  localparam int ERR_W = 16;
  localparam int CNT_W = 16;
  localparam int TOL_W = 15;
  localparam int RATE_W = 16;
  localparam int ERR_DIV_STEPS = 16;
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_ONLY_ACC = 3'd1;
  localparam logic [2:0] REG_TOL = 3'd2;
  localparam logic [2:0] REG_WINDOW = 3'd3;
  localparam logic [2:0] REG_RATE = 3'd4;
endpackage

### hdl/quadrant_detector_gain_calibration_unit.sv
// quadrant detector gain calibration, top level with shared multiplier and divider
// action 0: four shared multiplies, each a multiply state then an accumulate state, before the result registers
// action 1: the serial divider computes two error quotients and, when the gains are updated, four gain
// renormalizations, one quotient bit per cycle
// one word is in work at a time; the next word is taken the cycle after the result registers
// rst is synchronous: unity gains, zero errors and counter, registers at reset values
`timescale 1ns / 1ps
`include "quadrant_detector_gain_calibration_unit_assert.svh"
module quadrant_detector_gain_calibration_unit
  import qdgc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic s_tvalid,
  output logic s_tready,
  // intensity_a, intensity_b, intensity_c, intensity_d
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // action, accepted
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // calibrated_a..d, error_x, error_y, converged, gain_a..d
  output logic [((4*CAL_W+2*ERR_W+1+4*(GAIN_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);
  localparam int S = SAMPLE_BITS;
  localparam int F = GAIN_FRAC_BITS;
  localparam int GW = F + 1;
  localparam int DW = (S > F) ? S + 3 : F + 3;
  localparam int QW = (F + 2 > ERR_DIV_STEPS) ? F + 2 : ERR_DIV_STEPS;
  localparam int KW = $clog2(QW + 1);
  localparam int MA = (S > RATE_W ? S : RATE_W) + 1;
  localparam int MB = (GW > 18) ? GW + 1 : 18;
  localparam int PW = MA + MB;
  localparam int OW = ((4*CAL_W+2*ERR_W+1+4*GW+7)/8)*8;
  localparam int SH = 31 - F;
  localparam logic [GW-1:0] GAIN_ONE = GW'(1) << F;
  localparam logic [GW-1:0] GAIN_LO = GW'(1) << (F - 1);
  localparam logic [GW-1:0] GAIN_HI = GAIN_ONE + GAIN_LO;
  localparam logic [GW-1:0] GAIN_MAX = {GW{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMUL = 3'd1;
  localparam logic [2:0] S_CACC = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_STAB = 3'd5;
  localparam logic [2:0] S_SMUL = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state;
  logic enable_calibration, only_accepted;
  logic [TOL_W-1:0] target_tolerance;
  logic [CNT_W-1:0] stable_window, stable_count;
  logic [RATE_W-1:0] feedback_rate;
  logic converged_flag;
  logic signed [ERR_W-1:0] last_error_x, last_error_y;
  logic [GW-1:0] gain [4];
  logic [CAL_W-1:0] cal [4];
  logic [S-1:0] iv [4];
  logic [1:0] idx;
  logic [2:0] div_sel;
  logic [DW-1:0] rem, dsr;
  logic [QW-1:0] quo;
  logic [KW-1:0] cnt;
  logic [S+1:0] isum;
  logic [S+1:0] absy;
  logic negx, negy;
  logic [F+2:0] gsum;
  logic signed [PW-1:0] prod;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic m_valid;
  logic [OW-1:0] m_data;

  assign pready = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = m_valid;
  assign m_tdata = m_data;

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_ENABLE: prdata = 32'(enable_calibration);
      REG_ONLY_ACC: prdata = 32'(only_accepted);
      REG_TOL: prdata = 32'(target_tolerance);
      REG_WINDOW: prdata = 32'(stable_window);
      REG_RATE: prdata = 32'(feedback_rate);
      default: prdata = '0;
    endcase
  end

  // shared multiplier operands
  logic signed [ERR_W+1:0] delta;
  always_comb begin
    case (idx)
      2'd0: delta = -((ERR_W+2)'(last_error_x) + (ERR_W+2)'(last_error_y));
      2'd1: delta = (ERR_W+2)'(last_error_x) - (ERR_W+2)'(last_error_y);
      2'd2: delta = (ERR_W+2)'(last_error_x) + (ERR_W+2)'(last_error_y);
      default: delta = (ERR_W+2)'(last_error_y) - (ERR_W+2)'(last_error_x);
    endcase
    if (state == S_CMUL) begin
      mul_a = $signed({1'b0, (MA-1)'(iv[idx])});
      mul_b = $signed({1'b0, (MB-1)'(gain[idx])});
    end else begin
      mul_a = $signed({1'b0, (MA-1)'(feedback_rate)});
      mul_b = MB'(delta);
    end
  end

  // divider step and stage values
  logic [DW:0] rem2;
  logic q_bit;
  logic [QW-1:0] quo_next;
  logic signed [PW-1:0] step;
  logic signed [PW+1:0] gnew;
  logic [GW-1:0] gclamp;
  logic [S+2:0] dx, dy;
  logic [S+1:0] s_sum;
  logic [ERR_W:0] magx, magy;
  logic [TOL_W-1:0] tol_eff;
  logic [CNT_W-1:0] win_eff, count_next;
  logic conv_next;
  logic signed [ERR_W-1:0] err_res;
  logic [ERR_W-1:0] qe;
  always_comb begin
    rem2 = {rem, 1'b0};
    q_bit = (rem2 >= {1'b0, dsr});
    quo_next = {quo[QW-2:0], q_bit};
    step = prod >>> SH;
    gnew = (PW+2)'(gain[idx]) + (PW+2)'(step);
    if (gnew < $signed((PW+2)'(GAIN_LO))) gclamp = GAIN_LO;
    else if (gnew > $signed((PW+2)'(GAIN_HI))) gclamp = GAIN_HI;
    else gclamp = gnew[GW-1:0];
    s_sum = (S+2)'(iv[0]) + (S+2)'(iv[1]) + (S+2)'(iv[2]) + (S+2)'(iv[3]);
    dx = ((S+3)'(iv[0]) + (S+3)'(iv[3])) - ((S+3)'(iv[1]) + (S+3)'(iv[2]));
    dy = ((S+3)'(iv[0]) + (S+3)'(iv[1])) - ((S+3)'(iv[2]) + (S+3)'(iv[3]));
    qe = quo_next[ERR_W-1:0];
    if ((div_sel == 3'd0) ? negx : negy) err_res = -$signed(qe);
    else if (qe[ERR_W-1]) err_res = 16'sh7fff;
    else err_res = $signed(qe);
    magx = last_error_x[ERR_W-1] ? -(ERR_W+1)'(last_error_x) : (ERR_W+1)'(last_error_x);
    magy = last_error_y[ERR_W-1] ? -(ERR_W+1)'(last_error_y) : (ERR_W+1)'(last_error_y);
    tol_eff = (target_tolerance == '0) ? TOL_W'(1) : target_tolerance;
    win_eff = (stable_window == '0) ? CNT_W'(1) : stable_window;
    if (magx < (ERR_W+1)'(tol_eff) && magy < (ERR_W+1)'(tol_eff))
      count_next = (stable_count == '1) ? stable_count : stable_count + 1'b1;
    else
      count_next = '0;
    conv_next = converged_flag || (count_next >= win_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      enable_calibration <= 1'b0;
      only_accepted <= 1'b0;
      target_tolerance <= TOL_W'(33);
      stable_window <= CNT_W'(1);
      feedback_rate <= '0;
      converged_flag <= 1'b0;
      stable_count <= '0;
      last_error_x <= '0;
      last_error_y <= '0;
      for (int i = 0; i < 4; i++) gain[i] <= GAIN_ONE;
      m_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_ENABLE: enable_calibration <= pwdata[0];
          REG_ONLY_ACC: only_accepted <= pwdata[0];
          REG_TOL: target_tolerance <= pwdata[TOL_W-1:0];
          REG_WINDOW: stable_window <= pwdata[CNT_W-1:0];
          REG_RATE: feedback_rate <= pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (m_valid && m_tready && state != S_OUT) m_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 4; i++) begin
              iv[i] <= s_tdata[i*S +: S];
              cal[i] <= '0;
            end
            idx <= 2'd0;
            div_sel <= 3'd0;
            if (!s_tuser[0]) begin
              state <= S_CMUL;
            end else if (!enable_calibration) begin
              last_error_x <= '0;
              last_error_y <= '0;
              state <= S_OUT;
            end else if (only_accepted && !s_tuser[1]) begin
              state <= S_OUT;
            end else begin
              state <= S_DLOAD;
            end
          end
        end
        S_CMUL: begin
          prod <= mul_a * mul_b;
          state <= S_CACC;
        end
        S_CACC: begin
          if (enable_calibration) cal[idx] <= prod[F +: CAL_W];
          else cal[idx] <= CAL_W'(iv[idx]);
          idx <= idx + 1'b1;
          state <= (idx == 2'd3) ? S_OUT : S_CMUL;
        end
        S_DLOAD: begin
          if (div_sel == 3'd0) begin
            if (s_sum == '0) begin
              state <= S_OUT;
            end else begin
              isum <= s_sum;
              absy <= dy[S+2] ? (S+2)'(-dy) : dy[S+1:0];
              negx <= dx[S+2];
              negy <= dy[S+2];
              rem <= DW'(dx[S+2] ? (S+2)'(-dx) : dx[S+1:0]);
              dsr <= DW'({s_sum, 1'b0});
              cnt <= KW'(ERR_DIV_STEPS);
              quo <= '0;
              state <= S_DIV;
            end
          end else if (div_sel == 3'd1) begin
            rem <= DW'(absy);
            dsr <= DW'({isum, 1'b0});
            cnt <= KW'(ERR_DIV_STEPS);
            quo <= '0;
            state <= S_DIV;
          end else begin
            rem <= DW'(gain[div_sel[1:0] - 2'd2]);
            dsr <= DW'(gsum);
            cnt <= KW'(F + 2);
            quo <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= q_bit ? DW'(rem2 - {1'b0, dsr}) : DW'(rem2);
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == KW'(1)) begin
            div_sel <= div_sel + 1'b1;
            if (div_sel == 3'd0) begin
              last_error_x <= err_res;
              state <= S_DLOAD;
            end else if (div_sel == 3'd1) begin
              last_error_y <= err_res;
              state <= S_STAB;
            end else begin
              gain[div_sel[1:0] - 2'd2] <=
                (quo_next > QW'(GAIN_MAX)) ? GAIN_MAX : quo_next[GW-1:0];
              state <= (div_sel == 3'd5) ? S_OUT : S_DLOAD;
            end
          end
        end
        S_STAB: begin
          stable_count <= count_next;
          converged_flag <= conv_next;
          idx <= 2'd0;
          gsum <= '0;
          state <= (feedback_rate == '0 || conv_next) ? S_OUT : S_SMUL;
        end
        S_SMUL: begin
          // multiply into prod while cnt is zero, then add and clamp using the registered product
          prod <= mul_a * mul_b;
          if (cnt == '0) begin
            cnt <= KW'(1);
          end else begin
            cnt <= '0;
            gain[idx] <= gclamp;
            gsum <= gsum + (F+3)'(gclamp);
            idx <= idx + 1'b1;
            if (idx == 2'd3) state <= S_DLOAD;
          end
        end
        S_OUT: begin
          if (!m_valid || m_tready) begin
            m_valid <= 1'b1;
            m_data <= OW'({gain[3], gain[2], gain[1], gain[0], converged_flag,
                           last_error_y, last_error_x, cal[3], cal[2], cal[1], cal[0]});
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_STAB) cnt <= '0;
    end
  end

  `QDG_ASSERT_NEXT(a_conv_sticky, converged_flag, converged_flag)
  `QDG_ASSERT_ALWAYS(a_busy_not_ready, (state == S_IDLE) || !s_tready)
  `QDG_ASSERT_ALWAYS(a_div_count, (state != S_DIV) || (cnt != '0 && cnt <= KW'(QW)))
endmodule
